@@ src/assert_macros.svh @@
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every cycle outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ src/rfbp_pkg.sv @@
`timescale 1ns / 1ps
package rfbp_pkg;
  localparam int unsigned MAX_TEXT_BYTES = 1048576;
  localparam int unsigned TEXT_W = $clog2(MAX_TEXT_BYTES + 1);
  localparam int unsigned HDR_DEPTH = 20;
  localparam int unsigned HDR_BITS = 8 * HDR_DEPTH;
  localparam logic [4:0] VERSION_LEN = 5'd12;
  localparam logic [4:0] PIXFMT_LEN = 5'd20;
  localparam logic [4:0] UPDATE_LEN = 5'd10;
  localparam logic [4:0] KEY_LEN = 5'd8;
  localparam logic [4:0] POINTER_LEN = 5'd6;

  localparam logic [31:0] ENC_DESKTOP_SIZE = 32'hFFFF_FF21;
  localparam logic [31:0] ENC_EXT_DESKTOP_SIZE = 32'hFFFF_FECC;
  localparam logic [31:0] ENC_CURSOR = 32'hFFFF_FF11;

  localparam logic [7:0] MSG_PIXFMT = 8'd0;
  localparam logic [7:0] MSG_ENCODINGS = 8'd2;
  localparam logic [7:0] MSG_UPDATE = 8'd3;
  localparam logic [7:0] MSG_KEY = 8'd4;
  localparam logic [7:0] MSG_POINTER = 8'd5;
  localparam logic [7:0] MSG_CUT_TEXT = 8'd6;

  localparam logic [3:0] KIND_SEC_TYPES = 4'd0;
  localparam logic [3:0] KIND_SEC_RESULT = 4'd1;
  localparam logic [3:0] KIND_SERVER_INIT = 4'd2;
  localparam logic [3:0] KIND_PIXFMT = 4'd3;
  localparam logic [3:0] KIND_ENCODINGS = 4'd4;
  localparam logic [3:0] KIND_UPDATE = 4'd5;
  localparam logic [3:0] KIND_KEY = 4'd6;
  localparam logic [3:0] KIND_POINTER = 4'd7;
  localparam logic [3:0] KIND_CUT_TEXT = 4'd8;
  localparam logic [3:0] KIND_ERROR = 4'd9;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_SECURITY = 3'd1;
  localparam logic [2:0] ERR_BPP = 3'd2;
  localparam logic [2:0] ERR_MESSAGE = 3'd3;
  localparam logic [2:0] ERR_TEXT_LEN = 3'd4;

  localparam logic [1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    PH_VERSION, PH_SECURITY, PH_INIT, PH_RUN, PH_CLOSED
  } phase_t;

  // Classified beat handed from the front parser to the result builder.
  typedef enum logic [2:0] {
    OP_PLAIN, OP_PIXFMT, OP_UPDATE, OP_KEY, OP_POINTER
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] kind;
    logic       flag;
    logic [7:0] small_value;
    logic       last;
    logic [2:0] error_code;
    logic [2:0] encoding_flags;
    logic [8:0][7:0] hb;   // header bytes 1..9 for short messages
  } cmd_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic        flag;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic [15:0] third_value;
    logic [15:0] fourth_value;
    logic [7:0]  small_value;
    logic [31:0] word_value;
    logic        last;
    logic [2:0]  error_code;
    logic [2:0]  encoding_flags;
  } result_t;
endpackage

@@ src/rfbp_stream_if.sv @@
`timescale 1ns / 1ps
interface rfbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rfbp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic        flag;
  logic [15:0] first_value;
  logic [15:0] second_value;
  logic [15:0] third_value;
  logic [15:0] fourth_value;
  logic [7:0]  small_value;
  logic [31:0] word_value;
  logic        last;
  logic [2:0]  error_code;
  logic [2:0]  encoding_flags;
  modport source (output valid, output kind, output flag, output first_value,
    output second_value, output third_value, output fourth_value,
    output small_value, output word_value, output last, output error_code,
    output encoding_flags, input ready);
  modport sink (input valid, input kind, input flag, input first_value,
    input second_value, input third_value, input fourth_value,
    input small_value, input word_value, input last, input error_code,
    input encoding_flags, output ready);
endinterface

@@ src/rfbp_front.sv @@
`timescale 1ns / 1ps
module rfbp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [7:0]                    in_data_byte,
  output logic                          in_ready,
  output logic                          cmd_valid,
  output rfbp_pkg::cmd_t                cmd,
  output logic [rfbp_pkg::HDR_BITS-1:0] pix_hdr,
  input  logic                          cmd_ready
);
  rfbp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  message_type_r, message_type_nxt;
  logic [4:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  header_bytes_r [rfbp_pkg::HDR_DEPTH];
  logic [15:0] encodings_left_r, encodings_left_nxt;
  logic [31:0] encoding_word_r, encoding_word_nxt;
  logic [rfbp_pkg::TEXT_W-1:0] text_left_r, text_left_nxt;
  logic [2:0]  support_flags_r, support_flags_nxt;
  logic        hdr_we;
  logic [15:0] enc_count;
  logic [31:0] text_len;
  logic [31:0] enc_word;
  logic        emit;
  rfbp_pkg::cmd_t c;
  logic        accept;
  logic [4:0]  need;

  assign in_ready = cmd_ready;
  assign accept = in_valid && in_ready;
  assign cmd_valid = accept && emit;
  assign cmd = c;
  assign enc_word = {encoding_word_r[23:0], in_data_byte};
  assign enc_count = {header_bytes_r[2], in_data_byte};
  assign text_len = {header_bytes_r[4], header_bytes_r[5], header_bytes_r[6], in_data_byte};

  always_comb begin
    for (int i = 0; i < rfbp_pkg::HDR_DEPTH; i++) begin
      pix_hdr[8*i +: 8] = header_bytes_r[i];
    end
    pix_hdr[8*19 +: 8] = in_data_byte;
  end

  always_comb begin
    case (message_type_r)
      rfbp_pkg::MSG_PIXFMT: need = rfbp_pkg::PIXFMT_LEN;
      rfbp_pkg::MSG_UPDATE: need = rfbp_pkg::UPDATE_LEN;
      rfbp_pkg::MSG_KEY:    need = rfbp_pkg::KEY_LEN;
      default:              need = rfbp_pkg::POINTER_LEN;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    message_type_nxt = message_type_r;
    byte_index_nxt = byte_index_r;
    encodings_left_nxt = encodings_left_r;
    encoding_word_nxt = encoding_word_r;
    text_left_nxt = text_left_r;
    support_flags_nxt = support_flags_r;
    hdr_we = 1'b0;
    emit = 1'b0;
    c = '0;
    c.op = rfbp_pkg::OP_PLAIN;
    for (int i = 0; i < 9; i++) begin
      c.hb[i] = (byte_index_r == 5'(i + 1)) ? in_data_byte : header_bytes_r[i + 1];
    end
    case (phase_r)
      rfbp_pkg::PH_VERSION: begin
        byte_index_nxt = byte_index_r + 5'd1;
        if (byte_index_r == rfbp_pkg::VERSION_LEN - 5'd1) begin
          byte_index_nxt = '0;
          phase_nxt = rfbp_pkg::PH_SECURITY;
          emit = 1'b1;
          c.kind = rfbp_pkg::KIND_SEC_TYPES;
        end
      end
      rfbp_pkg::PH_SECURITY: begin
        emit = 1'b1;
        if (in_data_byte != 8'd1) begin
          phase_nxt = rfbp_pkg::PH_CLOSED;
          c.kind = rfbp_pkg::KIND_ERROR;
          c.error_code = rfbp_pkg::ERR_SECURITY;
        end else begin
          phase_nxt = rfbp_pkg::PH_INIT;
          c.kind = rfbp_pkg::KIND_SEC_RESULT;
        end
      end
      rfbp_pkg::PH_INIT: begin
        emit = 1'b1;
        phase_nxt = rfbp_pkg::PH_RUN;
        byte_index_nxt = '0;
        c.kind = rfbp_pkg::KIND_SERVER_INIT;
      end
      rfbp_pkg::PH_RUN: begin
        if (byte_index_r == 5'd0) begin
          if (!(in_data_byte inside {rfbp_pkg::MSG_PIXFMT,
                [rfbp_pkg::MSG_ENCODINGS:rfbp_pkg::MSG_CUT_TEXT]})) begin
            emit = 1'b1;
            phase_nxt = rfbp_pkg::PH_CLOSED;
            c.kind = rfbp_pkg::KIND_ERROR;
            c.error_code = rfbp_pkg::ERR_MESSAGE;
          end else begin
            message_type_nxt = in_data_byte;
            hdr_we = 1'b1;
            byte_index_nxt = 5'd1;
          end
        end else if (message_type_r == rfbp_pkg::MSG_ENCODINGS) begin
          if (byte_index_r < 5'd4) begin
            hdr_we = 1'b1;
            byte_index_nxt = byte_index_r + 5'd1;
            if (byte_index_r == 5'd3) begin
              encodings_left_nxt = enc_count;
              if (enc_count == 16'd0) begin
                emit = 1'b1;
                byte_index_nxt = '0;
                c.kind = rfbp_pkg::KIND_ENCODINGS;
                c.encoding_flags = support_flags_r;
              end
            end
          end else begin
            encoding_word_nxt = enc_word;
            byte_index_nxt = byte_index_r + 5'd1;
            if (byte_index_r == 5'd7) begin
              byte_index_nxt = 5'd4;
              if (enc_word == rfbp_pkg::ENC_DESKTOP_SIZE) begin
                support_flags_nxt = support_flags_r | 3'b001;
              end else if (enc_word == rfbp_pkg::ENC_EXT_DESKTOP_SIZE) begin
                support_flags_nxt = support_flags_r | 3'b010;
              end else if (enc_word == rfbp_pkg::ENC_CURSOR) begin
                support_flags_nxt = support_flags_r | 3'b100;
              end
              encodings_left_nxt = encodings_left_r - 16'd1;
              if (encodings_left_r == 16'd1) begin
                emit = 1'b1;
                byte_index_nxt = '0;
                c.kind = rfbp_pkg::KIND_ENCODINGS;
                c.encoding_flags = support_flags_nxt;
              end
            end
          end
        end else if (message_type_r == rfbp_pkg::MSG_CUT_TEXT) begin
          if (byte_index_r < 5'd8) begin
            hdr_we = 1'b1;
            byte_index_nxt = byte_index_r + 5'd1;
            if (byte_index_r == 5'd7) begin
              if (text_len > 32'(rfbp_pkg::MAX_TEXT_BYTES)) begin
                emit = 1'b1;
                phase_nxt = rfbp_pkg::PH_CLOSED;
                c.kind = rfbp_pkg::KIND_ERROR;
                c.error_code = rfbp_pkg::ERR_TEXT_LEN;
              end else if (text_len == 32'd0) begin
                emit = 1'b1;
                byte_index_nxt = '0;
                c.kind = rfbp_pkg::KIND_CUT_TEXT;
                c.last = 1'b1;
              end else begin
                text_left_nxt = text_len[rfbp_pkg::TEXT_W-1:0];
              end
            end
          end else begin
            emit = 1'b1;
            text_left_nxt = text_left_r - rfbp_pkg::TEXT_W'(1);
            c.kind = rfbp_pkg::KIND_CUT_TEXT;
            c.flag = 1'b1;
            c.small_value = in_data_byte;
            if (text_left_r == rfbp_pkg::TEXT_W'(1)) begin
              c.last = 1'b1;
              byte_index_nxt = '0;
            end
          end
        end else begin
          hdr_we = 1'b1;
          byte_index_nxt = byte_index_r + 5'd1;
          if (byte_index_r + 5'd1 >= need) begin
            emit = 1'b1;
            byte_index_nxt = '0;
            case (message_type_r)
              rfbp_pkg::MSG_PIXFMT: begin
                if (header_bytes_r[4] inside {8'd8, 8'd16, 8'd32}) begin
                  c.op = rfbp_pkg::OP_PIXFMT;
                end else begin
                  phase_nxt = rfbp_pkg::PH_CLOSED;
                  c.kind = rfbp_pkg::KIND_ERROR;
                  c.error_code = rfbp_pkg::ERR_BPP;
                end
              end
              rfbp_pkg::MSG_UPDATE: c.op = rfbp_pkg::OP_UPDATE;
              rfbp_pkg::MSG_KEY:    c.op = rfbp_pkg::OP_KEY;
              default:              c.op = rfbp_pkg::OP_POINTER;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rfbp_pkg::PH_VERSION;
      message_type_r <= '0;
      byte_index_r <= '0;
      encodings_left_r <= '0;
      encoding_word_r <= '0;
      text_left_r <= '0;
      support_flags_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      message_type_r <= message_type_nxt;
      byte_index_r <= byte_index_nxt;
      encodings_left_r <= encodings_left_nxt;
      encoding_word_r <= encoding_word_nxt;
      text_left_r <= text_left_nxt;
      support_flags_r <= support_flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hdr_we && byte_index_r < 5'(rfbp_pkg::HDR_DEPTH)) begin
      header_bytes_r[byte_index_r] <= in_data_byte;
    end
  end
endmodule

@@ src/rfbp_back.sv @@
`timescale 1ns / 1ps
module rfbp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  rfbp_pkg::cmd_t                cmd,
  input  logic [rfbp_pkg::HDR_BITS-1:0] pix_hdr,
  output logic                          cmd_ready,
  input  logic [15:0]                   frame_width,
  input  logic [15:0]                   frame_height,
  output logic                          res_valid,
  output rfbp_pkg::result_t             res,
  input  logic                          res_ready
);
  // Two-entry queue of classified beats, then the result is built on the way out.
  rfbp_pkg::cmd_t   q_cmd_r [2];
  logic [rfbp_pkg::HDR_BITS-1:0] q_hdr_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       push, pop;
  rfbp_pkg::cmd_t h;
  logic [rfbp_pkg::HDR_BITS-1:0] ph;
  rfbp_pkg::result_t r;
  logic [7:0]  bpp;
  logic [15:0] px, py;
  logic        clamp;

  function automatic logic [7:0] hb(input logic [rfbp_pkg::HDR_BITS-1:0] v, input int i);
    hb = v[8*i +: 8];
  endfunction

  assign cmd_ready = (count_r != 2'd2);
  assign push = cmd_valid && cmd_ready;
  assign pop = res_valid && res_ready;
  assign res_valid = (count_r != 2'd0);
  assign h = q_cmd_r[rd_ptr_r];
  assign ph = q_hdr_r[rd_ptr_r];
  assign res = r;
  assign bpp = hb(ph, 4);
  assign clamp = frame_width != 16'd0 && frame_height != 16'd0;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_comb begin
    px = {h.hb[1], h.hb[2]};
    py = {h.hb[3], h.hb[4]};
    if (clamp && px > frame_width - 16'd1) begin
      px = frame_width - 16'd1;
    end
    if (clamp && py > frame_height - 16'd1) begin
      py = frame_height - 16'd1;
    end
  end

  always_comb begin
    r = '0;
    r.kind = h.kind;
    r.flag = h.flag;
    r.small_value = h.small_value;
    r.last = h.last;
    r.error_code = h.error_code;
    r.encoding_flags = h.encoding_flags;
    case (h.op)
      rfbp_pkg::OP_PIXFMT: begin
        r.kind = rfbp_pkg::KIND_PIXFMT;
        r.first_value = {hb(ph, 8), hb(ph, 9)};
        r.second_value = {hb(ph, 10), hb(ph, 11)};
        r.third_value = {hb(ph, 12), hb(ph, 13)};
        r.fourth_value = {8'd0, hb(ph, 7)};
        r.small_value = bpp;
        r.word_value = {hb(ph, 5), 7'd0, hb(ph, 6) != 8'd0, 1'b0,
          ph[8*14 +: 5], ph[8*15 +: 5], ph[8*16 +: 5]};
      end
      rfbp_pkg::OP_UPDATE: begin
        r.kind = rfbp_pkg::KIND_UPDATE;
        r.flag = h.hb[0] != 8'd0;
        r.first_value = {h.hb[1], h.hb[2]};
        r.second_value = {h.hb[3], h.hb[4]};
        r.third_value = {h.hb[5], h.hb[6]};
        r.fourth_value = {h.hb[7], h.hb[8]};
      end
      rfbp_pkg::OP_KEY: begin
        r.kind = rfbp_pkg::KIND_KEY;
        r.flag = h.hb[0] != 8'd0;
        r.word_value = {h.hb[3], h.hb[4], h.hb[5], h.hb[6]};
      end
      rfbp_pkg::OP_POINTER: begin
        r.kind = rfbp_pkg::KIND_POINTER;
        r.first_value = px;
        r.second_value = py;
        r.small_value = h.hb[0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd_r[wr_ptr_r] <= cmd;
      q_hdr_r[wr_ptr_r] <= pix_hdr;
    end
  end
endmodule

@@ src/rfb_client_message_parser.sv @@
`timescale 1ns / 1ps
// RFB client stream parser: one byte beat per cycle when the result side keeps up.
// Each result is queued when the byte that completes it is accepted and built on the way out.
// Throughput: one byte per cycle while the two-entry queue has room; the queue absorbs result stalls.
// Reset: synchronous active-low rst_n returns to the version phase and
// clears the frame size registers.
module rfb_client_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  rfbp_in_if.sink     in_if,
  rfbp_out_if.source  out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [15:0] frame_width_r, frame_height_r;
  logic cmd_valid, cmd_ready, res_valid;
  rfbp_pkg::cmd_t cmd;
  rfbp_pkg::result_t res;
  logic [rfbp_pkg::HDR_BITS-1:0] pix_hdr;
  logic [1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx = cfg_paddr[2:2] == 1'b1 ? rfbp_pkg::CFG_FRAME_HEIGHT
                                          : rfbp_pkg::CFG_FRAME_WIDTH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= '0;
      frame_height_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      case (cfg_idx)
        rfbp_pkg::CFG_FRAME_WIDTH:  frame_width_r <= cfg_pwdata[15:0];
        rfbp_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rfbp_pkg::CFG_FRAME_WIDTH:  cfg_prdata = {16'd0, frame_width_r};
      rfbp_pkg::CFG_FRAME_HEIGHT: cfg_prdata = {16'd0, frame_height_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  rfbp_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_data_byte(in_if.data_byte), .in_ready(in_if.ready),
    .cmd_valid(cmd_valid), .cmd(cmd), .pix_hdr(pix_hdr), .cmd_ready(cmd_ready)
  );

  rfbp_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd(cmd), .pix_hdr(pix_hdr), .cmd_ready(cmd_ready),
    .frame_width(frame_width_r), .frame_height(frame_height_r),
    .res_valid(res_valid), .res(res), .res_ready(out_if.ready)
  );

  assign out_if.valid = res_valid;
  assign out_if.kind = res.kind;
  assign out_if.flag = res.flag;
  assign out_if.first_value = res.first_value;
  assign out_if.second_value = res.second_value;
  assign out_if.third_value = res.third_value;
  assign out_if.fourth_value = res.fourth_value;
  assign out_if.small_value = res.small_value;
  assign out_if.word_value = res.word_value;
  assign out_if.last = res.last;
  assign out_if.error_code = res.error_code;
  assign out_if.encoding_flags = res.encoding_flags;
endmodule

@@ src/rfbp_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rfbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_kind,
  input logic [2:0] out_error_code,
  input logic       out_flag,
  input logic       out_last
);
  // error beats carry a code, others none
  `CHK_IMPLY(a_err_code, clk, rst_n, out_valid && out_kind == rfbp_pkg::KIND_ERROR, out_error_code != rfbp_pkg::ERR_NONE, "error beat without code")
  `CHK_IMPLY(a_no_code, clk, rst_n, out_valid && out_kind != rfbp_pkg::KIND_ERROR, out_error_code == rfbp_pkg::ERR_NONE, "code on non-error beat")
  `CHK_IMPLY(a_empty_text, clk, rst_n, out_valid && out_kind == rfbp_pkg::KIND_CUT_TEXT && !out_flag, out_last, "empty text not last")
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind), "stalled beat changed")
endmodule

bind rfb_client_message_parser rfbp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_kind(out_if.kind), .out_error_code(out_if.error_code),
  .out_flag(out_if.flag), .out_last(out_if.last)
);

@@ verif/rfb_client_message_parser_tb.sv @@
`timescale 1ns / 1ps
module rfb_client_message_parser_tb;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned ITEM_TARGET = 1700;

  class ParseScoreboard;
    rfbp_pkg::phase_t  ph;
    logic [7:0]        msg_type;
    int                idx;
    logic [7:0]        hdr[rfbp_pkg::HDR_DEPTH];
    logic [15:0]       enc_left;
    logic [31:0]       enc_word;
    int unsigned       text_left;
    logic [2:0]        enc_flags;
    logic [15:0]       fb_width;
    logic [15:0]       fb_height;
    rfbp_pkg::result_t pending[$];
    int                errors;

    function new();
      ph = rfbp_pkg::PH_VERSION;
      msg_type = 0;
      idx = 0;
      enc_left = 0;
      enc_word = 0;
      text_left = 0;
      enc_flags = 0;
      fb_width = 0;
      fb_height = 0;
      errors = 0;
      foreach (hdr[i]) hdr[i] = 0;
    endfunction

    function logic [15:0] hw(int at);
      return {hdr[at], hdr[at + 1]};
    endfunction

    function void close_session(output rfbp_pkg::result_t r, input logic [2:0] code);
      ph = rfbp_pkg::PH_CLOSED;
      r = '0;
      r.kind = rfbp_pkg::KIND_ERROR;
      r.error_code = code;
    endfunction

    function void finish_fixed(output rfbp_pkg::result_t r);
      logic [15:0] x;
      logic [15:0] y;
      r = '0;
      idx = 0;
      if (msg_type == rfbp_pkg::MSG_PIXFMT) begin
        if (hdr[4] != 8 && hdr[4] != 16 && hdr[4] != 32) begin
          close_session(r, rfbp_pkg::ERR_BPP);
        end else begin
          r.kind = rfbp_pkg::KIND_PIXFMT;
          r.first_value = hw(8);
          r.second_value = hw(10);
          r.third_value = hw(12);
          r.fourth_value = {8'd0, hdr[7]};
          r.small_value = hdr[4];
          r.word_value = {hdr[5], 7'd0, hdr[6] != 0, 1'b0, hdr[14][4:0], hdr[15][4:0],
                          hdr[16][4:0]};
        end
      end else if (msg_type == rfbp_pkg::MSG_UPDATE) begin
        r.kind = rfbp_pkg::KIND_UPDATE;
        r.flag = hdr[1] != 0;
        r.first_value = hw(2);
        r.second_value = hw(4);
        r.third_value = hw(6);
        r.fourth_value = hw(8);
      end else if (msg_type == rfbp_pkg::MSG_KEY) begin
        r.kind = rfbp_pkg::KIND_KEY;
        r.flag = hdr[1] != 0;
        r.word_value = {hw(4), hw(6)};
      end else begin
        x = hw(2);
        y = hw(4);
        if (fb_width != 0 && fb_height != 0) begin
          if (x > fb_width - 16'd1) x = fb_width - 16'd1;
          if (y > fb_height - 16'd1) y = fb_height - 16'd1;
        end
        r.kind = rfbp_pkg::KIND_POINTER;
        r.first_value = x;
        r.second_value = y;
        r.small_value = hdr[1];
      end
    endfunction

    function bit run_byte(input logic [7:0] b, output rfbp_pkg::result_t r);
      logic [31:0] len;
      int need;
      r = '0;
      if (idx == 0) begin
        if (b != rfbp_pkg::MSG_PIXFMT &&
            (b < rfbp_pkg::MSG_ENCODINGS || b > rfbp_pkg::MSG_CUT_TEXT)) begin
          close_session(r, rfbp_pkg::ERR_MESSAGE);
          return 1;
        end
        msg_type = b;
        hdr[0] = b;
        idx = 1;
        return 0;
      end
      if (msg_type == rfbp_pkg::MSG_ENCODINGS) begin
        if (idx < 4) begin
          hdr[idx] = b;
          idx++;
          if (idx == 4) begin
            enc_left = hw(2);
            if (enc_left == 0) begin
              idx = 0;
              r.kind = rfbp_pkg::KIND_ENCODINGS;
              r.encoding_flags = enc_flags;
              return 1;
            end
          end
          return 0;
        end
        enc_word = {enc_word[23:0], b};
        idx++;
        if (idx < 8) return 0;
        idx = 4;
        if (enc_word == rfbp_pkg::ENC_DESKTOP_SIZE) enc_flags[0] = 1'b1;
        else if (enc_word == rfbp_pkg::ENC_EXT_DESKTOP_SIZE) enc_flags[1] = 1'b1;
        else if (enc_word == rfbp_pkg::ENC_CURSOR) enc_flags[2] = 1'b1;
        enc_left--;
        if (enc_left == 0) begin
          idx = 0;
          r.kind = rfbp_pkg::KIND_ENCODINGS;
          r.encoding_flags = enc_flags;
          return 1;
        end
        return 0;
      end
      if (msg_type == rfbp_pkg::MSG_CUT_TEXT) begin
        if (idx < 8) begin
          hdr[idx] = b;
          idx++;
          if (idx < 8) return 0;
          len = {hw(4), hw(6)};
          if (len > rfbp_pkg::MAX_TEXT_BYTES) begin
            close_session(r, rfbp_pkg::ERR_TEXT_LEN);
            return 1;
          end
          if (len == 0) begin
            idx = 0;
            r.kind = rfbp_pkg::KIND_CUT_TEXT;
            r.last = 1'b1;
            return 1;
          end
          text_left = len;
          return 0;
        end
        text_left--;
        r.kind = rfbp_pkg::KIND_CUT_TEXT;
        r.flag = 1'b1;
        r.small_value = b;
        if (text_left == 0) begin
          r.last = 1'b1;
          idx = 0;
        end
        return 1;
      end
      if (idx < rfbp_pkg::HDR_DEPTH) hdr[idx] = b;
      idx++;
      need = msg_type == rfbp_pkg::MSG_PIXFMT ? rfbp_pkg::PIXFMT_LEN :
             msg_type == rfbp_pkg::MSG_UPDATE ? rfbp_pkg::UPDATE_LEN :
             msg_type == rfbp_pkg::MSG_KEY ? rfbp_pkg::KEY_LEN : rfbp_pkg::POINTER_LEN;
      if (idx >= need) begin
        finish_fixed(r);
        return 1;
      end
      return 0;
    endfunction

    function void note_byte(logic [7:0] b);
      rfbp_pkg::result_t r;
      bit has;
      r = '0;
      has = 0;
      case (ph)
        rfbp_pkg::PH_VERSION: begin
          idx++;
          if (idx >= rfbp_pkg::VERSION_LEN) begin
            idx = 0;
            ph = rfbp_pkg::PH_SECURITY;
            r.kind = rfbp_pkg::KIND_SEC_TYPES;
            has = 1;
          end
        end
        rfbp_pkg::PH_SECURITY: begin
          has = 1;
          if (b != 8'd1) close_session(r, rfbp_pkg::ERR_SECURITY);
          else begin
            ph = rfbp_pkg::PH_INIT;
            r.kind = rfbp_pkg::KIND_SEC_RESULT;
          end
        end
        rfbp_pkg::PH_INIT: begin
          ph = rfbp_pkg::PH_RUN;
          idx = 0;
          r.kind = rfbp_pkg::KIND_SERVER_INIT;
          has = 1;
        end
        rfbp_pkg::PH_RUN: has = run_byte(b, r);
        default: has = 0;
      endcase
      if (has) pending.push_back(r);
    endfunction

    function void check_result(rfbp_pkg::result_t got);
      rfbp_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind || got.flag !== want.flag ||
          got.first_value !== want.first_value || got.second_value !== want.second_value ||
          got.third_value !== want.third_value || got.fourth_value !== want.fourth_value ||
          got.small_value !== want.small_value || got.word_value !== want.word_value ||
          got.last !== want.last || got.error_code !== want.error_code ||
          got.encoding_flags !== want.encoding_flags) begin
        $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  bit          calm;
  int unsigned quiet_cycles;
  int unsigned sent;
  logic [7:0]  beats[$];
  ParseScoreboard sb;

  rfbp_in_if in_bus ();
  rfbp_out_if out_bus ();

  rfb_client_message_parser DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_bus), .out_if(out_bus),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_bus.ready <= rst_n && (calm || $urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sb.check_result('{kind: out_bus.kind, flag: out_bus.flag,
        first_value: out_bus.first_value, second_value: out_bus.second_value,
        third_value: out_bus.third_value, fourth_value: out_bus.fourth_value,
        small_value: out_bus.small_value, word_value: out_bus.word_value,
        last: out_bus.last, error_code: out_bus.error_code,
        encoding_flags: out_bus.encoding_flags});
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [1:0] index, logic [15:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {index[0], 2'b00};
    cfg_pwdata <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (index == rfbp_pkg::CFG_FRAME_WIDTH) sb.fb_width = value;
    else sb.fb_height = value;
  endtask

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = (!calm && $urandom_range(99) < 22) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_byte(b);
    sent++;
  endtask

  task automatic flush_beats();
    while (beats.size() > 0) send_byte(beats.pop_front());
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(4))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(1, 2000));
    endcase
  endfunction

  function automatic void add16(logic [15:0] v);
    beats.push_back(v[15:8]);
    beats.push_back(v[7:0]);
  endfunction

  function automatic void add_pixfmt(logic [7:0] bpp);
    beats.push_back(rfbp_pkg::MSG_PIXFMT);
    repeat (3) beats.push_back(8'($urandom));
    beats.push_back(bpp);
    repeat (15) beats.push_back(8'($urandom));
  endfunction

  function automatic void add_encodings(int n);
    logic [31:0] w;
    beats.push_back(rfbp_pkg::MSG_ENCODINGS);
    beats.push_back(8'($urandom));
    add16(16'(n));
    repeat (n) begin
      case ($urandom_range(5))
        0: w = rfbp_pkg::ENC_DESKTOP_SIZE;
        1: w = rfbp_pkg::ENC_EXT_DESKTOP_SIZE;
        2: w = rfbp_pkg::ENC_CURSOR;
        default: w = $urandom;
      endcase
      add16(w[31:16]);
      add16(w[15:0]);
    end
  endfunction

  function automatic void add_fixed(logic [7:0] code, int len);
    beats.push_back(code);
    repeat (len - 1) beats.push_back(8'($urandom));
  endfunction

  function automatic void add_pointer(logic [15:0] x, logic [15:0] y);
    beats.push_back(rfbp_pkg::MSG_POINTER);
    beats.push_back(8'($urandom));
    add16(x);
    add16(y);
  endfunction

  function automatic void add_cut_text(logic [31:0] len, int body);
    beats.push_back(rfbp_pkg::MSG_CUT_TEXT);
    repeat (3) beats.push_back(8'($urandom));
    add16(len[31:16]);
    add16(len[15:0]);
    repeat (body) beats.push_back(8'($urandom));
  endfunction

  initial begin
    int choice;
    sb = new();
    rst_n = 1'b0;
    calm = 1'b0;
    quiet_cycles = 0;
    sent = 0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = 8'd0;
    out_bus.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = 3'd0;
    cfg_pwdata = 32'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    cfg_write(rfbp_pkg::CFG_FRAME_WIDTH, 16'd0);
    cfg_write(rfbp_pkg::CFG_FRAME_HEIGHT, 16'd0);

    beats.push_back(8'h00);
    beats.push_back(8'hFF);
    repeat (10) beats.push_back(8'($urandom));
    beats.push_back(8'd1);
    beats.push_back(8'($urandom));
    add_pixfmt(8'd32);
    add_encodings(0);
    add_pointer(16'hFFFF, 16'hFFFF);
    flush_beats();
    drain();
    cfg_write(rfbp_pkg::CFG_FRAME_WIDTH, 16'd640);
    cfg_write(rfbp_pkg::CFG_FRAME_HEIGHT, 16'd480);
    add_pointer(16'hFFFF, 16'd0);
    add_pointer(16'd639, 16'd480);
    add_encodings(3);
    add_fixed(rfbp_pkg::MSG_UPDATE, rfbp_pkg::UPDATE_LEN);
    add_fixed(rfbp_pkg::MSG_KEY, rfbp_pkg::KEY_LEN);
    add_cut_text(0, 0);
    add_cut_text(2, 2);
    add_pixfmt(8'd8);
    add_pixfmt(8'd16);
    flush_beats();

    while (sent < ITEM_TARGET) begin
      if (sent % 300 < 25) begin
        drain();
        cfg_write(rfbp_pkg::CFG_FRAME_WIDTH, pick_size());
        cfg_write(rfbp_pkg::CFG_FRAME_HEIGHT, pick_size());
      end
      calm = sent >= 700 && sent < 1000;
      case ($urandom_range(5))
        0: begin
          choice = $urandom_range(2);
          add_pixfmt(choice == 0 ? 8'd8 : choice == 1 ? 8'd16 : 8'd32);
        end
        1: add_encodings($urandom_range(0, 5));
        2: add_fixed(rfbp_pkg::MSG_UPDATE, rfbp_pkg::UPDATE_LEN);
        3: add_fixed(rfbp_pkg::MSG_KEY, rfbp_pkg::KEY_LEN);
        4: add_pointer(16'($urandom), 16'($urandom));
        default: begin
          choice = $urandom_range(0, 8);
          add_cut_text(choice, choice);
        end
      endcase
      flush_beats();
    end
    calm = 1'b0;

    case ($urandom_range(2))
      0: add_pixfmt(8'd24);
      1: beats.push_back(8'($urandom_range(7, 255)));
      default: add_cut_text(rfbp_pkg::MAX_TEXT_BYTES + 1, 0);
    endcase
    repeat (20) beats.push_back(8'($urandom));
    flush_beats();
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ rfb_client_message_parser.f @@
+incdir+src
src/rfbp_pkg.sv
src/rfbp_stream_if.sv
src/rfbp_front.sv
src/rfbp_back.sv
src/rfb_client_message_parser.sv
src/rfbp_checker.sv
verif/rfb_client_message_parser_tb.sv
